### hw/rtl/greedy_word_wrap_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the greedy word wrap unit
// Implication helpers with clock and asynchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef GREEDY_WORD_WRAP_UNIT_MACROS_SVH
`define GREEDY_WORD_WRAP_UNIT_MACROS_SVH

// same-cycle implication
`define GWW_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GWW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/gww_pkg.sv
// ----------------------------------------------------------------------------
// gww_pkg
// Shared types, register indexes and byte helpers of the word wrap unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gww_pkg;

	// inserted and input line break byte
	localparam logic [7:0] NEWLINE_BYTE = 8'd10;

	// results per input beat are capped at this count
	localparam int unsigned CNT_W = 6;
	localparam logic [CNT_W-1:0] RESULT_LIMIT = 6'd63;

	// configuration register indexes
	localparam logic REG_LINE_WIDTH = 1'b0;
	localparam logic REG_DROP_NL    = 1'b1;

	// reset values of the registers
	localparam logic [5:0] LINE_WIDTH_RST = 6'd40;

	// sequencer states, one-hot
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CHECK = 4'b0010,
		ST_READ  = 4'b0100,
		ST_FLUSH = 4'b1000
	} state_t;

	// ASCII letter or digit
	function automatic logic is_word_byte(input logic [7:0] b);
		return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
			(b >= 8'h61 && b <= 8'h7A);
	endfunction

endpackage

`default_nettype wire

### hw/rtl/greedy_word_wrap_unit.sv
// A beat that causes no break frees the input once the check state returns to
// idle. A break of L bytes streams out with its newline at one result per
// cycle from the single line store read port, unless the output stalls.
// The input is stalled from acceptance until the last result is handed over.
// Reset clears the fill count and control; line width returns to 40, drop off.
// ----------------------------------------------------------------------------
// greedy_word_wrap_unit
// Collects text bytes in a circular line store and emits wrapped lines,
// breaking after the last non-alphanumeric byte, or after all if none is held.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module greedy_word_wrap_unit #(
	parameter int unsigned MAX_WIDTH = 60
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// configuration
	input  wire logic       cfg_we,
	input  wire logic       cfg_index,
	input  wire logic [5:0] cfg_data,
	// input channel
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] text_byte,
	input  wire logic       end_of_text,
	// output channel
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_byte,
	output logic            run_last
);

	localparam int unsigned AW = $clog2(MAX_WIDTH);
	localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
	localparam int unsigned SW = CW + 1;

	// configuration registers
	logic [5:0] line_width_q;
	logic       drop_nl_q;

	// store bookkeeping
	logic [AW-1:0] head_q;
	logic [CW-1:0] fill_q;
	logic [CW-1:0] sep_q;   // bytes up to and including the last separator

	// sequencer
	gww_pkg::state_t      state_q;
	logic                 first_q;
	logic                 last_q;
	logic [AW-1:0]        rd_ptr_q;
	logic [CW-1:0]        rem_q;
	logic                 rv_s1;
	logic [7:0]           rdata_s1;
	logic [gww_pkg::CNT_W-1:0] cnt_q;

	// held result and output register
	logic       pend_v_q;
	logic [7:0] pend_byte_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       run_last_q;

	logic [7:0] mem [MAX_WIDTH];

	logic          in_acc;
	logic          adv;
	logic          has_room;
	logic [CW-1:0] w_eff;
	logic [SW-1:0] tail_sum;
	logic [AW-1:0] wr_addr;
	logic [CW-1:0] chunk_len;
	logic [SW-1:0] head_sum;
	logic [AW-1:0] head_nxt;
	logic [AW-1:0] rd_ptr_nxt;
	logic          take;
	logic          issue;
	logic          emit_req;
	logic [7:0]    emit_byte;
	logic          emit_ok;
	logic          push;
	logic [7:0]    push_byte;
	logic          push_last;

	assign in_stall  = (state_q != gww_pkg::ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign adv       = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_last  = run_last_q;
	assign has_room  = (fill_q < CW'(MAX_WIDTH));

	// effective width, clamped to 1..MAX_WIDTH
	always_comb begin
		if (line_width_q == 6'd0) begin
			w_eff = CW'(1);
		end else if ({1'b0, line_width_q} > 7'(MAX_WIDTH)) begin
			w_eff = CW'(MAX_WIDTH);
		end else begin
			w_eff = CW'(line_width_q);
		end
	end

	// circular address arithmetic
	always_comb begin
		tail_sum = SW'(head_q) + SW'(fill_q);
		if (tail_sum >= SW'(MAX_WIDTH)) begin
			tail_sum = tail_sum - SW'(MAX_WIDTH);
		end
		wr_addr = tail_sum[AW-1:0];

		chunk_len = (sep_q != '0) ? sep_q : fill_q;
		head_sum  = SW'(head_q) + SW'(chunk_len);
		if (head_sum >= SW'(MAX_WIDTH)) begin
			head_sum = head_sum - SW'(MAX_WIDTH);
		end
		head_nxt = head_sum[AW-1:0];

		rd_ptr_nxt = (rd_ptr_q == AW'(MAX_WIDTH - 1)) ? '0 : rd_ptr_q + AW'(1);
	end

	// break decision: width break once per beat, then flush on end of text
	assign take  = (first_q && fill_q >= w_eff) || (last_q && fill_q != '0);
	assign issue = (state_q == gww_pkg::ST_READ) && adv && (rem_q != '0);

	// result producer: stored byte, or closing newline of the chunk
	always_comb begin
		emit_req  = 1'b0;
		emit_byte = gww_pkg::NEWLINE_BYTE;
		if (state_q == gww_pkg::ST_READ && adv) begin
			if (rv_s1) begin
				emit_req  = !(drop_nl_q && rdata_s1 == gww_pkg::NEWLINE_BYTE);
				emit_byte = rdata_s1;
			end else if (rem_q == '0) begin
				emit_req = 1'b1;
			end
		end
		emit_ok = emit_req && (cnt_q < gww_pkg::RESULT_LIMIT);
	end

	// held result moves on when a newer one arrives, or as the final one
	always_comb begin
		push      = 1'b0;
		push_byte = pend_byte_q;
		push_last = 1'b0;
		if (emit_ok && pend_v_q) begin
			push = 1'b1;
		end else if (state_q == gww_pkg::ST_FLUSH && adv && pend_v_q) begin
			push      = 1'b1;
			push_last = 1'b1;
		end
	end

	// line store: one write, one registered read
	always_ff @(posedge clk) begin
		if (in_acc && has_room) begin
			mem[wr_addr] <= text_byte;
		end
		if (issue) begin
			rdata_s1 <= mem[rd_ptr_q];
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= gww_pkg::LINE_WIDTH_RST;
			drop_nl_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gww_pkg::REG_LINE_WIDTH: line_width_q <= cfg_data;
				gww_pkg::REG_DROP_NL:    drop_nl_q    <= cfg_data[0];
				default:                 ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= push || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_byte_q <= push_byte;
			run_last_q <= push_last;
		end
	end

	// sequencer and store bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gww_pkg::ST_IDLE;
			head_q      <= '0;
			fill_q      <= '0;
			sep_q       <= '0;
			first_q     <= 1'b0;
			last_q      <= 1'b0;
			rd_ptr_q    <= '0;
			rem_q       <= '0;
			rv_s1       <= 1'b0;
			cnt_q       <= '0;
			pend_v_q    <= 1'b0;
			pend_byte_q <= '0;
		end else begin
			// newest result is held until the next one or the end of the beat
			if (emit_ok) begin
				cnt_q       <= cnt_q + gww_pkg::CNT_W'(1);
				pend_byte_q <= emit_byte;
				pend_v_q    <= 1'b1;
			end

			unique case (state_q)
				gww_pkg::ST_IDLE: begin
					if (in_acc) begin
						cnt_q   <= '0;
						first_q <= 1'b1;
						last_q  <= end_of_text;
						if (has_room) begin
							fill_q <= fill_q + CW'(1);
							if (!gww_pkg::is_word_byte(text_byte)) begin
								sep_q <= fill_q + CW'(1);
							end
						end
						state_q <= gww_pkg::ST_CHECK;
					end
				end
				gww_pkg::ST_CHECK: begin
					if (take) begin
						head_q   <= head_nxt;
						fill_q   <= fill_q - chunk_len;
						sep_q    <= '0;
						rd_ptr_q <= head_q;
						rem_q    <= chunk_len;
						rv_s1    <= 1'b0;
						first_q  <= 1'b0;
						state_q  <= gww_pkg::ST_READ;
					end else if (pend_v_q) begin
						state_q <= gww_pkg::ST_FLUSH;
					end else begin
						state_q <= gww_pkg::ST_IDLE;
					end
				end
				gww_pkg::ST_READ: begin
					if (adv) begin
						if (rem_q != '0) begin
							rd_ptr_q <= rd_ptr_nxt;
							rem_q    <= rem_q - CW'(1);
							rv_s1    <= 1'b1;
						end else begin
							rv_s1 <= 1'b0;
							if (!rv_s1) begin
								state_q <= gww_pkg::ST_CHECK;
							end
						end
					end
				end
				gww_pkg::ST_FLUSH: begin
					if (adv) begin
						pend_v_q <= 1'b0;
						state_q  <= gww_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= gww_pkg::ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### hw/rtl/gww_checker.sv
// ----------------------------------------------------------------------------
// gww_checker
// Port-level checks of the word wrap unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "greedy_word_wrap_unit_macros.svh"

module gww_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] out_byte,
	input wire logic       run_last
);

	// a stalled output beat holds
	`GWW_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(out_byte) && $stable(run_last), "output beat changed under stall")

	// an accepted input keeps the unit busy in the next cycle
	`GWW_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall,
		"input taken twice in a row")

	// while a beat of an unfinished run is offered, no new input is taken
	`GWW_ASSERT_NOW(a_run_open, clk, arst_n, out_valid && !run_last, in_stall,
		"input open while run incomplete")

endmodule

bind greedy_word_wrap_unit gww_checker u_gww_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_byte  (out_byte),
	.run_last  (run_last)
);

`default_nettype wire

### verif/greedy_word_wrap_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_word_wrap_unit_test
// Self-checking bench for the word wrap unit. A short table of hand-picked
// text beats and register writes runs first, then eight random phases of
// word-shaped text at different line widths and newline modes. Every
// accepted text beat goes through an in-bench line-breaking model, and each
// output beat is checked in order against that model or the typed table bytes.
// ----------------------------------------------------------------------------

module greedy_word_wrap_unit_test;

	localparam int LINE_MAX = 60;
	localparam int SETTLE   = 8;

	// one predicted output beat
	typedef struct packed {
		logic [7:0] b;
		logic       last;
	} wrap_out_t;

	// one row of the directed table: a register write or a text beat
	typedef struct {
		logic       is_cfg;
		logic       idx;
		logic [5:0] val;
		logic [7:0] c;
		logic       eot;
		int         typed;   // -1: use the line model, else count of typed bytes
		logic [7:0] e0;
		logic [7:0] e1;
	} plan_row_t;

	logic       clk;
	logic       arst_n      = 1'b0;
	logic       cfg_we      = 1'b0;
	logic       cfg_index   = 1'b0;
	logic [5:0] cfg_data    = '0;
	logic       in_valid    = 1'b0;
	logic       in_stall;
	logic [7:0] text_byte   = 8'h20;
	logic       end_of_text = 1'b0;
	logic       out_valid;
	logic       out_stall   = 1'b0;
	logic [7:0] out_byte;
	logic       run_last;

	// typed expectation riding along with the current text beat
	int         row_typed = -1;
	logic [7:0] row_e0    = '0;
	logic [7:0] row_e1    = '0;

	// line model state
	logic [7:0] line_buf [LINE_MAX];
	int         held      = 0;
	logic [5:0] width_reg = gww_pkg::LINE_WIDTH_RST;
	logic       drop_reg  = 1'b0;
	wrap_out_t  step_out [$];
	wrap_out_t  wrap_pending [$];

	// run statistics
	int errors    = 0;
	int beats_in  = 0;
	int bytes_out = 0;
	int breaks    = 0;
	int flushes   = 0;

	// sender pacing
	int burst_left = 0;
	bit gaps_on    = 1'b1;
	int word_left  = 0;

	plan_row_t plan [$];

	greedy_word_wrap_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.run_last    (run_last)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// line model
	// ------------------------------------------------------------------
	function automatic logic is_alnum(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h61 && c <= 8'h7A);
	endfunction

	task automatic put_byte(input logic [7:0] c);
		wrap_out_t r;
		r.b    = c;
		r.last = 1'b0;
		if (step_out.size() < int'(gww_pkg::RESULT_LIMIT))
			step_out.push_back(r);
	endtask

	// cut after the last non-word byte, or take everything if all word bytes
	task automatic break_line();
		int cut;
		int k;
		cut = held;
		while (cut > 0 && is_alnum(line_buf[cut-1]))
			cut--;
		if (cut == 0)
			cut = held;
		for (k = 0; k < cut; k++) begin
			if (!(drop_reg && line_buf[k] == gww_pkg::NEWLINE_BYTE))
				put_byte(line_buf[k]);
		end
		put_byte(gww_pkg::NEWLINE_BYTE);
		for (k = cut; k < held; k++)
			line_buf[k-cut] = line_buf[k];
		held -= cut;
		breaks++;
	endtask

	task automatic wrap_step(input logic [7:0] c, input logic eot);
		int        lim;
		wrap_out_t tail;
		step_out.delete();
		lim = (width_reg == 0) ? 1 : ((width_reg > LINE_MAX) ? LINE_MAX : int'(width_reg));
		if (held < LINE_MAX) begin
			line_buf[held] = c;
			held++;
		end
		if (held >= lim)
			break_line();
		if (eot) begin
			flushes++;
			while (held > 0)
				break_line();
		end
		if (step_out.size() > 0) begin
			tail = step_out.pop_back();
			tail.last = 1'b1;
			step_out.push_back(tail);
		end
	endtask

	// ------------------------------------------------------------------
	// monitor: predict on accepted text beats, check output beats
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		wrap_out_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				beats_in++;
				wrap_step(text_byte, end_of_text);
				if (row_typed >= 0) begin
					// directed row: expected bytes typed into the table
					if (row_typed >= 1) begin
						want.b    = row_e0;
						want.last = (row_typed == 1);
						wrap_pending.push_back(want);
					end
					if (row_typed >= 2) begin
						want.b    = row_e1;
						want.last = 1'b1;
						wrap_pending.push_back(want);
					end
				end else begin
					foreach (step_out[i])
						wrap_pending.push_back(step_out[i]);
				end
			end
			if (out_valid && !out_stall) begin
				if (wrap_pending.size() == 0) begin
					errors++;
					$display("%0t ns: output beat with nothing expected: out_byte=%02h run_last=%0b",
						$time, out_byte, run_last);
				end else begin
					want = wrap_pending.pop_front();
					bytes_out++;
					if (out_byte !== want.b) begin
						errors++;
						$display("%0t ns: out_byte expected %02h actual %02h",
							$time, want.b, out_byte);
					end
					if (run_last !== want.last) begin
						errors++;
						$display("%0t ns: run_last expected %0b actual %0b",
							$time, want.last, run_last);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// receiver stall pattern in one of four modes, each picked at random
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		int unsigned cyc;
		int unsigned mode;
		if (cyc % 128 == 0)
			mode = $urandom_range(0, 3);
		case (mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= (cyc % 3 != 0);
		endcase
		cyc++;
	end

	// ------------------------------------------------------------------
	// sender helpers
	// ------------------------------------------------------------------
	// present one beat at a falling edge, hold until accepted
	task automatic send_beat(input logic [7:0] c, input logic eot, input int typed,
			input logic [7:0] e0, input logic [7:0] e1);
		text_byte   <= c;
		end_of_text <= eot;
		in_valid    <= 1'b1;
		row_typed   <= typed;
		row_e0      <= e0;
		row_e1      <= e1;
		do @(posedge clk); while (in_stall !== 1'b0);
		@(negedge clk);
	endtask

	// bursts of random length, with random gaps between them while gaps_on is set
	task automatic pace();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 24);
			if (gaps_on) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 7)) @(negedge clk);
			end
		end
	endtask

	// registers change only with nothing in flight
	task automatic write_reg(input logic idx, input logic [5:0] val);
		in_valid <= 1'b0;
		while (wrap_pending.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == gww_pkg::REG_LINE_WIDTH)
			width_reg = val;
		else
			drop_reg = val[0];
	endtask

	function automatic logic [7:0] pick_alnum();
		int v;
		v = $urandom_range(0, 61);
		if (v < 10)
			return 8'(8'h30 + v);
		else if (v < 36)
			return 8'(8'h41 + v - 10);
		return 8'(8'h61 + v - 36);
	endfunction

	// word-shaped text with some noise bytes mixed in
	task automatic next_text(output logic [7:0] c);
		int r;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			c = 8'($urandom_range(1, 255));
		end else if (word_left > 0) begin
			word_left--;
			c = pick_alnum();
		end else begin
			case ($urandom_range(0, 11))
				0, 1, 2, 3, 4, 5: c = 8'h20;
				6: c = gww_pkg::NEWLINE_BYTE;
				7: c = 8'h2C;
				8: c = 8'h2E;
				9: c = 8'h2D;
				10: c = 8'h21;
				default: c = 8'h3B;
			endcase
			// occasional long word forces a hard break
			word_left = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 70)
				: $urandom_range(1, 8);
		end
	endtask

	task automatic add_beat(input logic [7:0] c, input logic eot, input int typed,
			input logic [7:0] e0, input logic [7:0] e1);
		plan_row_t r;
		r.is_cfg = 1'b0;
		r.idx    = 1'b0;
		r.val    = '0;
		r.c      = c;
		r.eot    = eot;
		r.typed  = typed;
		r.e0     = e0;
		r.e1     = e1;
		plan.push_back(r);
	endtask

	task automatic add_cfg(input logic idx, input logic [5:0] val);
		plan_row_t r;
		r.is_cfg = 1'b1;
		r.idx    = idx;
		r.val    = val;
		r.c      = '0;
		r.eot    = 1'b0;
		r.typed  = -1;
		r.e0     = '0;
		r.e1     = '0;
		plan.push_back(r);
	endtask

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	initial begin : stimulus
		logic [7:0] c;
		int         w;
		int         k;

		// reset defaults: width 40, newlines kept
		add_beat(8'h41, 1'b1, 2, 8'h41, gww_pkg::NEWLINE_BYTE);
		// drop mode: a lone input newline leaves only the inserted break
		add_cfg(gww_pkg::REG_DROP_NL, 6'd1);
		add_beat(gww_pkg::NEWLINE_BYTE, 1'b1, 1, gww_pkg::NEWLINE_BYTE, 8'h00);
		add_cfg(gww_pkg::REG_DROP_NL, 6'd0);
		// narrowest line: every beat breaks
		add_cfg(gww_pkg::REG_LINE_WIDTH, 6'd1);
		add_beat(8'h7A, 1'b0, 2, 8'h7A, gww_pkg::NEWLINE_BYTE);
		add_beat(8'hFF, 1'b0, 2, 8'hFF, gww_pkg::NEWLINE_BYTE);
		add_beat(8'h01, 1'b0, 2, 8'h01, gww_pkg::NEWLINE_BYTE);
		add_beat(8'h80, 1'b0, -1, 8'h00, 8'h00);
		// widest line, fill a few bytes
		add_cfg(gww_pkg::REG_LINE_WIDTH, 6'd60);
		add_beat(8'h30, 1'b0, 0, 8'h00, 8'h00);
		add_beat(8'h39, 1'b0, -1, 8'h00, 8'h00);
		add_beat(8'h20, 1'b0, -1, 8'h00, 8'h00);
		add_beat(8'h5A, 1'b0, -1, 8'h00, 8'h00);
		add_beat(8'h61, 1'b0, -1, 8'h00, 8'h00);
		// width drops below the fill level
		add_cfg(gww_pkg::REG_LINE_WIDTH, 6'd2);
		add_beat(8'h62, 1'b0, -1, 8'h00, 8'h00);
		add_cfg(gww_pkg::REG_DROP_NL, 6'd1);
		add_beat(gww_pkg::NEWLINE_BYTE, 1'b0, -1, 8'h00, 8'h00);
		// bytes just outside the letter and digit ranges
		add_beat(8'h2F, 1'b0, -1, 8'h00, 8'h00);
		add_beat(8'h40, 1'b0, -1, 8'h00, 8'h00);
		add_cfg(gww_pkg::REG_LINE_WIDTH, 6'd16);
		add_cfg(gww_pkg::REG_DROP_NL, 6'd0);
		add_beat(8'h3A, 1'b0, -1, 8'h00, 8'h00);
		add_beat(8'h5B, 1'b0, -1, 8'h00, 8'h00);
		add_beat(8'h60, 1'b0, -1, 8'h00, 8'h00);
		add_beat(8'h7B, 1'b0, -1, 8'h00, 8'h00);
		add_beat(8'h7F, 1'b0, -1, 8'h00, 8'h00);
		add_beat(8'h51, 1'b0, -1, 8'h00, 8'h00);
		// flush with two chunks left in the store
		add_beat(8'h37, 1'b1, -1, 8'h00, 8'h00);

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				write_reg(plan[i].idx, plan[i].val);
			end else begin
				send_beat(plan[i].c, plan[i].eot, plan[i].typed, plan[i].e0, plan[i].e1);
				pace();
			end
		end

		// random phases: width extremes and mid values, both newline modes
		for (int phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: w = 60;
				1: w = 1;
				2: w = $urandom_range(2, 12);
				default: w = $urandom_range(13, 59);
			endcase
			write_reg(gww_pkg::REG_LINE_WIDTH, 6'(w));
			write_reg(gww_pkg::REG_DROP_NL, 6'(((phase >> 2) ^ phase) & 1));
			gaps_on = (phase % 3 != 0);
			for (k = 0; k < 50; k++) begin
				next_text(c);
				send_beat(c, ($urandom_range(0, 29) == 0), -1, 8'h00, 8'h00);
				pace();
			end
		end
		in_valid <= 1'b0;

		// drain, then give the block time to show any stray beat
		while (wrap_pending.size() != 0)
			@(negedge clk);
		repeat (24) @(negedge clk);

		$display("Wrapped %0d text beats into %0d output beats, %0d line breaks, %0d flushes.",
			beats_in, bytes_out, breaks, flushes);
		$display("Widths 1 to 60 and both newline modes, including width cut below the fill.");
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// hard stop well beyond the slowest legal run
	initial begin : watchdog
		#10_000_000;
		$display("Timeout with %0d output beats still expected.", wrap_pending.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/gww_pkg.sv
hw/rtl/greedy_word_wrap_unit.sv
hw/rtl/gww_checker.sv
verif/greedy_word_wrap_unit_test.sv
